### hw/rtl/coastline_contour_outliner_assert.svh
// ----------------------------------------------------------------------------
// Coastline contour outliner assertion macros
// Shared property forms for the checker, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef COASTLINE_CONTOUR_OUTLINER_ASSERT_SVH
`define COASTLINE_CONTOUR_OUTLINER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCO_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCO_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cco_pkg.sv
// ----------------------------------------------------------------------------
// Coastline contour outliner package
// Codes, colours, register indexes and default sizes shared by the block.
// ----------------------------------------------------------------------------
package cco_pkg;

  localparam int CODE_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIM_REG_W = 9;

  localparam int DEF_MAX_WIDTH = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_LOWEST_CODE = 6;

  localparam logic [CODE_W-1:0] COL_BLACK = 16'd0;
  localparam logic [CODE_W-1:0] COL_WHITE = 16'd1;
  localparam logic [CODE_W-1:0] COL_OUTLINE_A = 16'd4;
  localparam logic [CODE_W-1:0] COL_OUTLINE_B = 16'd5;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEA_CODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTOUR_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTLINE_ONLY = 3'd4;

  localparam logic [DIM_REG_W-1:0] RST_FRAME_WIDTH = 9'd256;
  localparam logic [DIM_REG_W-1:0] RST_FRAME_HEIGHT = 9'd256;
  localparam logic [CODE_W-1:0] RST_SEA_CODE = 16'd32770;
  localparam logic [CODE_W-1:0] RST_CONTOUR_STEP = 16'd0;
  localparam logic RST_OUTLINE_ONLY = 1'b0;

endpackage

### hw/rtl/cco_ram.sv
// ----------------------------------------------------------------------------
// Coastline contour outliner RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module cco_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/coastline_contour_outliner.sv
// ----------------------------------------------------------------------------
// Coastline contour outliner
// Stores a frame of height-colour codes and returns recoloured pixels with
// coast and contour points marked.
// ----------------------------------------------------------------------------
// A write beat leaves the block ready at once. A read beat of an inner pixel
// runs through its states in order: ST_CENTRE fetches the centre code, ST_SCAN
// runs a restoring subtractor one quotient bit per cycle while the eight
// neighbours stream out of the single frame memory read port, ST_CMP compares
// the edge neighbours N, W, E, S against the next band threshold through one
// comparator, and ST_FINISH loads the result register once the last result is
// taken. A border pixel skips ST_SCAN and ST_CMP; an out-of-frame read goes
// straight to ST_FINISH. No new beat is taken while a read is in progress,
// but a finished result may wait in its register as the next beat is taken.
module coastline_contour_outliner
  import cco_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int LOWEST_CODE = DEF_LOWEST_CODE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  logic                  mode,
  input  logic [7:0]            col_x,
  input  logic [7:0]            row_y,
  input  logic [CODE_W-1:0]     pixel_code,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [CODE_W-1:0]     colour_code,
  output logic                  is_outline,
  output logic                  bad_coord
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DIM_A = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                         $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int DIM_W = (DIM_A > DIM_REG_W) ? DIM_A : DIM_REG_W;
  localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(MAX_WIDTH);
  localparam logic [ADDR_W-1:0] ADDR_ONE = ADDR_W'(1);
  localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);
  localparam logic [CODE_W-1:0] LOWEST = CODE_W'(LOWEST_CODE);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_SCAN,
    ST_CMP,
    ST_FINISH
  } state_t;

  state_t state;

  logic [DIM_REG_W-1:0] frame_width;
  logic [DIM_REG_W-1:0] frame_height;
  logic [CODE_W-1:0]    sea_code;
  logic [CODE_W-1:0]    contour_step;
  logic                 outline_only;

  logic [ADDR_W-1:0] base;
  logic              inner;
  logic              bad;
  logic [CODE_W-1:0] centre;
  logic              centre_ge_land;
  logic              coast_en;
  logic              contour_en;
  logic              land_seen;
  logic              contour_hit;
  logic [3:0]        rd_idx;
  logic [4:0]        div_cnt;
  logic [CODE_W-1:0] rem;
  logic [CODE_W-1:0] quo;
  logic [1:0]        cmp_idx;
  logic [CODE_W:0]   thr;
  logic [CODE_W-1:0] edge_nb [4];

  logic [DIM_W-1:0]  w_lim;
  logic [DIM_W-1:0]  h_lim;
  logic [DIM_W-1:0]  x_ext;
  logic [DIM_W-1:0]  y_ext;
  logic              in_frame;
  logic              inner_in;
  logic [ADDR_W-1:0] addr_in;
  logic              cmd_fire;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CODE_W-1:0] ram_rdata;
  logic [CODE_W:0]   land;
  logic [CODE_W:0]   rdata_ext;
  logic [CODE_W:0]   diff;
  logic [CODE_W:0]   div_trial;
  logic [CODE_W+1:0] div_sub;
  logic              div_ge;
  logic              pix_edge;
  logic [CODE_W-1:0] pix_colour;

  function automatic logic [ADDR_W-1:0] nb_addr(input logic [ADDR_W-1:0] b,
                                                input logic [2:0] k);
    logic [ADDR_W-1:0] a;
    case (k)
      3'd0: a = b - ROW_STEP - ADDR_ONE;
      3'd1: a = b - ROW_STEP;
      3'd2: a = b - ROW_STEP + ADDR_ONE;
      3'd3: a = b - ADDR_ONE;
      3'd4: a = b + ADDR_ONE;
      3'd5: a = b + ROW_STEP - ADDR_ONE;
      3'd6: a = b + ROW_STEP;
      default: a = b + ROW_STEP + ADDR_ONE;
    endcase
    return a;
  endfunction

  always_comb begin
    w_lim = (DIM_W'(frame_width) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                      : DIM_W'(frame_width);
    h_lim = (DIM_W'(frame_height) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                        : DIM_W'(frame_height);
    x_ext = DIM_W'(col_x);
    y_ext = DIM_W'(row_y);
    in_frame = (x_ext < w_lim) && (y_ext < h_lim);
    inner_in = (col_x != 8'd0) && (row_y != 8'd0) &&
               (x_ext + DIM_ONE < w_lim) && (y_ext + DIM_ONE < h_lim);
    addr_in = ADDR_W'(row_y) * ROW_STEP + ADDR_W'(col_x);
  end

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_fire = cmd_valid && cmd_ready;
  assign ram_we = cmd_fire && (mode == MODE_WRITE) && in_frame;

  always_comb begin
    case (state)
      ST_IDLE: ram_raddr = addr_in;
      ST_CENTRE: ram_raddr = nb_addr(base, 3'd0);
      ST_SCAN: ram_raddr = nb_addr(base, rd_idx[2:0]);
      default: ram_raddr = base;
    endcase
  end

  cco_ram #(
    .WIDTH(CODE_W),
    .DEPTH(DEPTH)
  ) u_frame_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(addr_in),
    .wdata(pixel_code),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign land = {1'b0, sea_code} + 17'd1;
  assign rdata_ext = {1'b0, ram_rdata};
  assign diff = rdata_ext - land;

  assign div_trial = {rem, quo[CODE_W-1]};
  assign div_sub = {1'b0, div_trial} - {2'b00, contour_step};
  assign div_ge = !div_sub[CODE_W+1];

  always_comb begin
    pix_edge = inner && ((coast_en && land_seen) || contour_hit);
    if (pix_edge) begin
      if (outline_only) begin
        pix_colour = COL_BLACK;
      end else if ((contour_step == '0) || !centre_ge_land || quo[0]) begin
        pix_colour = COL_OUTLINE_A;
      end else begin
        pix_colour = COL_OUTLINE_B;
      end
    end else if (outline_only) begin
      pix_colour = (centre >= LOWEST) ? COL_WHITE : COL_BLACK;
    end else begin
      pix_colour = centre;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      sea_code <= RST_SEA_CODE;
      contour_step <= RST_CONTOUR_STEP;
      outline_only <= RST_OUTLINE_ONLY;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_FRAME_WIDTH: frame_width <= cfg_wdata[DIM_REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_wdata[DIM_REG_W-1:0];
        REG_SEA_CODE: sea_code <= cfg_wdata;
        REG_CONTOUR_STEP: contour_step <= cfg_wdata;
        REG_OUTLINE_ONLY: outline_only <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && (state != ST_FINISH)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_fire && (mode == MODE_READ)) begin
            base <= addr_in;
            inner <= inner_in;
            bad <= !in_frame;
            state <= in_frame ? ST_CENTRE : ST_FINISH;
          end
        end
        ST_CENTRE: begin
          centre <= ram_rdata;
          centre_ge_land <= (rdata_ext >= land);
          coast_en <= (ram_rdata >= LOWEST) && (ram_rdata <= sea_code);
          contour_en <= (contour_step != '0) &&
                        ((rdata_ext >= land) ||
                         ((land - rdata_ext) < {1'b0, contour_step}));
          quo <= diff[CODE_W-1:0];
          rem <= '0;
          div_cnt <= '0;
          rd_idx <= 4'd1;
          land_seen <= 1'b0;
          contour_hit <= 1'b0;
          state <= inner ? ST_SCAN : ST_FINISH;
        end
        ST_SCAN: begin
          if (div_cnt != 5'd16) begin
            rem <= div_ge ? div_sub[CODE_W-1:0] : div_trial[CODE_W-1:0];
            quo <= {quo[CODE_W-2:0], div_ge};
            div_cnt <= div_cnt + 5'd1;
          end
          if (rd_idx != 4'd9) begin
            if (rdata_ext >= land) begin
              land_seen <= 1'b1;
            end
            case (rd_idx)
              4'd2: edge_nb[0] <= ram_rdata;
              4'd4: edge_nb[1] <= ram_rdata;
              4'd5: edge_nb[2] <= ram_rdata;
              4'd7: edge_nb[3] <= ram_rdata;
              default: ;
            endcase
            rd_idx <= rd_idx + 4'd1;
          end
          if ((div_cnt == 5'd16) && (rd_idx == 4'd9)) begin
            thr <= centre_ge_land ?
                   ({1'b0, centre} - {1'b0, rem} + {1'b0, contour_step}) :
                   (land + {1'b0, contour_step});
            cmp_idx <= '0;
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (contour_en && ({1'b0, edge_nb[cmp_idx]} >= thr)) begin
            contour_hit <= 1'b1;
          end
          cmp_idx <= cmp_idx + 2'd1;
          if (cmp_idx == 2'd3) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            colour_code <= bad ? COL_BLACK : pix_colour;
            is_outline <= !bad && pix_edge;
            bad_coord <= bad;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/cco_checker.sv
// ----------------------------------------------------------------------------
// Coastline contour outliner checker
// Port-level properties of the outliner, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "coastline_contour_outliner_assert.svh"

module cco_checker
  import cco_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input logic              mode,
  input logic              res_valid,
  input logic              res_ready,
  input logic [CODE_W-1:0] colour_code,
  input logic              is_outline,
  input logic              bad_coord
);

  `CCO_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(colour_code) && $stable(is_outline) && $stable(bad_coord), "Result beat changed while stalled.")

  `CCO_ASSERT_NOW(a_bad_blank, res_valid && bad_coord, colour_code == COL_BLACK && !is_outline, "Out-of-frame result is not blank.")

  `CCO_ASSERT_NOW(a_outline_colour, res_valid && is_outline, colour_code == COL_BLACK || colour_code == COL_OUTLINE_A || colour_code == COL_OUTLINE_B, "Outline point has a map colour.")

  `CCO_ASSERT_NEXT(a_read_busy, cmd_valid && cmd_ready && mode == MODE_READ, !cmd_ready, "Block stayed ready after a read beat.")

  `CCO_ASSERT_NEXT(a_write_quick, cmd_valid && cmd_ready && mode == MODE_WRITE, cmd_ready, "Block went busy after a write beat.")

endmodule

bind coastline_contour_outliner cco_checker u_cco_checker (.*);
